@@ hw/rtl/bmpt_pkg.sv @@
// Package for the binomial-mod-prime table block: constants, types, sequencer states.
`default_nettype none
package bmpt_pkg;

  // Prime modulus and its small multiples for the reduction step
  localparam logic [29:0] PRIME   = 30'd998244353;
  localparam logic [31:0] PRIME_1 = 32'd998244353;
  localparam logic [31:0] PRIME_2 = 32'd1996488706;
  localparam logic [31:0] PRIME_3 = 32'd2994733059;
  // Fermat exponent p-2
  localparam logic [29:0] PRIME_EXP = 30'd998244351;
  localparam int unsigned PRIME_BITS = 30;

  localparam int unsigned MAX_N_DEF = 4096;

  // Item modes
  localparam logic MODE_BUILD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [12:0] n_value;
    logic [12:0] r_value;
  } bmpt_in_t;

  typedef struct packed {
    logic [29:0] value;
    logic        error;
  } bmpt_out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_BINIT0,
    S_BINIT1,
    S_FWD,
    S_FWD_WR,
    S_EXP,
    S_EXP_ACC,
    S_EXP_SQ,
    S_EXP_SQW,
    S_INV_WR,
    S_BWD,
    S_BWD_WR,
    S_Q1,
    S_Q2,
    S_Q3,
    S_Q4,
    S_Q5,
    S_MUL,
    S_RED,
    S_DONE
  } bmpt_state_e;

endpackage
`default_nettype wire

@@ hw/rtl/binomial_mod_prime_table.sv @@
// Factorial / inverse-factorial tables mod 998244353 with binomial queries.
//
//   channel | direction | handshake              | word
//   in      | input     | in_valid_i / in_stall_o  | bmpt_in_t  (mode, n_value, r_value)
//   out     | output    | out_valid_o / out_stall_i | bmpt_out_t (value, error)
//
// Every modular product goes through one 30x30 multiplier and a radix-4 reduction
// unit: the product is formed first, then reduced two product bits per step.
// A query multiplies twice; a rejected query skips the products and goes to the output.
// Build with limit L (L clipped to MAX_N): factorials are formed upward; the inverse
// of L! comes from one exponentiation, lower inverses by multiplying back down.
// Reset clears the sequencer and the built flag; the tables are not cleared.
// The input is stalled while an item is in work; a finished word waits in the
// output register while the next item may already be taken.
`default_nettype none
module binomial_mod_prime_table import bmpt_pkg::*; #(
  parameter int unsigned MAX_N = MAX_N_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire bmpt_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output bmpt_out_t      out_data_o
);

  localparam int unsigned AW = $clog2(MAX_N + 1);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned DEPTH = MAX_N + 1;

  // Table memories
  logic [29:0] fact_mem [DEPTH];
  logic [29:0] inv_mem  [DEPTH];
  logic [29:0] fact_rd_q, inv_rd_q;

  bmpt_state_e state_q, state_d, ret_q, ret_d;
  logic [CW-1:0] i_q, i_d, lim_q, lim_d, built_q, built_d;
  logic          valid_tab_q, valid_tab_d;
  logic [12:0]   n_q, n_d, r_q, r_d;
  logic [29:0]   acc_q, acc_d, sq_q, sq_d, a_q, a_d, b_q, b_d, rem_q, rem_d;
  logic [59:0]   prod_q, prod_d;
  logic [4:0]    cnt_q, cnt_d, e_q, e_d;
  logic [29:0]   resv_q, resv_d;
  logic          rese_q, rese_d;
  logic          out_valid_q;
  bmpt_out_t     out_q;

  logic          accept, deliver;
  logic          fact_we, inv_we;
  logic [AW-1:0] fact_waddr, inv_waddr, fact_raddr, inv_raddr;
  logic [29:0]   fact_wdata, inv_wdata;
  logic [31:0]   red_t, red_r;
  logic [12:0]   diff;

  assign accept      = in_valid_i && !in_stall_o;
  assign deliver     = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign diff        = n_q - r_q;

  // Reduction step: shift in two product bits, subtract the largest multiple of p
  always_comb begin
    red_t = {rem_q, prod_q[59:58]};
    if (red_t >= PRIME_3) begin
      red_r = red_t - PRIME_3;
    end else if (red_t >= PRIME_2) begin
      red_r = red_t - PRIME_2;
    end else if (red_t >= PRIME_1) begin
      red_r = red_t - PRIME_1;
    end else begin
      red_r = red_t;
    end
  end

  // Next state and datapath registers
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    i_d         = i_q;
    lim_d       = lim_q;
    built_d     = built_q;
    valid_tab_d = valid_tab_q;
    n_d         = n_q;
    r_d         = r_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    a_d         = a_q;
    b_d         = b_q;
    rem_d       = rem_q;
    prod_d      = prod_q;
    cnt_d       = cnt_q;
    e_d         = e_q;
    resv_d      = resv_q;
    rese_d      = rese_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          n_d = in_data_i.n_value;
          r_d = in_data_i.r_value;
          if (in_data_i.mode == MODE_BUILD) begin
            lim_d   = (32'(in_data_i.n_value) > MAX_N) ? CW'(MAX_N)
                                                       : CW'(in_data_i.n_value);
            state_d = S_BINIT0;
          end else if (!valid_tab_q || (32'(in_data_i.n_value) > 32'(built_q)) ||
                       (in_data_i.r_value > in_data_i.n_value)) begin
            resv_d  = '0;
            rese_d  = 1'b1;
            state_d = S_DONE;
          end else begin
            state_d = S_Q1;
          end
        end
      end
      S_BINIT0: state_d = S_BINIT1;
      S_BINIT1: begin
        acc_d   = 30'd1;
        i_d     = CW'(2);
        state_d = S_FWD;
      end
      S_FWD: begin
        if (i_q > lim_q) begin
          sq_d    = acc_q;
          acc_d   = 30'd1;
          e_d     = '0;
          state_d = S_EXP;
        end else begin
          a_d     = acc_q;
          b_d     = 30'(i_q);
          ret_d   = S_FWD_WR;
          state_d = S_MUL;
        end
      end
      S_FWD_WR: begin
        acc_d   = rem_q;
        i_d     = i_q + CW'(1);
        state_d = S_FWD;
      end
      S_EXP: begin
        if (e_q == 5'(PRIME_BITS)) begin
          state_d = S_INV_WR;
        end else if (PRIME_EXP[e_q]) begin
          a_d     = acc_q;
          b_d     = sq_q;
          ret_d   = S_EXP_ACC;
          state_d = S_MUL;
        end else begin
          state_d = S_EXP_SQ;
        end
      end
      S_EXP_ACC: begin
        acc_d   = rem_q;
        state_d = S_EXP_SQ;
      end
      S_EXP_SQ: begin
        a_d     = sq_q;
        b_d     = sq_q;
        ret_d   = S_EXP_SQW;
        state_d = S_MUL;
      end
      S_EXP_SQW: begin
        sq_d    = rem_q;
        e_d     = e_q + 5'd1;
        state_d = S_EXP;
      end
      S_INV_WR: begin
        i_d     = lim_q;
        state_d = S_BWD;
      end
      S_BWD: begin
        if (i_q < CW'(2)) begin
          built_d     = lim_q;
          valid_tab_d = 1'b1;
          resv_d      = '0;
          rese_d      = 1'b0;
          state_d     = S_DONE;
        end else begin
          a_d     = acc_q;
          b_d     = 30'(i_q);
          ret_d   = S_BWD_WR;
          state_d = S_MUL;
        end
      end
      S_BWD_WR: begin
        acc_d   = rem_q;
        i_d     = i_q - CW'(1);
        state_d = S_BWD;
      end
      S_Q1: state_d = S_Q2;
      S_Q2: begin
        a_d     = fact_rd_q;
        b_d     = inv_rd_q;
        state_d = S_Q3;
      end
      S_Q3: begin
        sq_d    = inv_rd_q;
        ret_d   = S_Q4;
        state_d = S_MUL;
      end
      S_Q4: begin
        a_d     = rem_q;
        b_d     = sq_q;
        ret_d   = S_Q5;
        state_d = S_MUL;
      end
      S_Q5: begin
        resv_d  = rem_q;
        rese_d  = 1'b0;
        state_d = S_DONE;
      end
      S_MUL: begin
        prod_d  = a_q * b_q;
        rem_d   = '0;
        cnt_d   = '0;
        state_d = S_RED;
      end
      S_RED: begin
        rem_d  = red_r[29:0];
        prod_d = {prod_q[57:0], 2'b00};
        cnt_d  = cnt_q + 5'd1;
        if (cnt_q == 5'd29) begin
          state_d = ret_q;
        end
      end
      S_DONE: begin
        if (deliver) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Table write and read ports
  always_comb begin
    fact_we    = 1'b0;
    inv_we     = 1'b0;
    fact_waddr = '0;
    inv_waddr  = '0;
    fact_wdata = 30'd1;
    inv_wdata  = 30'd1;
    case (state_q)
      S_BINIT0: begin
        fact_we = 1'b1;
        inv_we  = 1'b1;
      end
      S_BINIT1: begin
        fact_we    = 1'b1;
        inv_we     = 1'b1;
        fact_waddr = AW'(1);
        inv_waddr  = AW'(1);
      end
      S_FWD_WR: begin
        fact_we    = 1'b1;
        fact_waddr = i_q[AW-1:0];
        fact_wdata = rem_q;
      end
      S_INV_WR: begin
        inv_we    = 1'b1;
        inv_waddr = lim_q[AW-1:0];
        inv_wdata = acc_q;
      end
      S_BWD_WR: begin
        inv_we    = 1'b1;
        inv_waddr = AW'(i_q - CW'(1));
        inv_wdata = rem_q;
      end
      default: begin
        fact_we = 1'b0;
      end
    endcase
  end

  assign fact_raddr = AW'(n_q);
  assign inv_raddr  = (state_q == S_Q1) ? AW'(r_q) : AW'(diff);

  always_ff @(posedge clk_i) begin
    if (fact_we) begin
      fact_mem[fact_waddr] <= fact_wdata;
    end
    if (inv_we) begin
      inv_mem[inv_waddr] <= inv_wdata;
    end
    fact_rd_q <= fact_mem[fact_raddr];
    inv_rd_q  <= inv_mem[inv_raddr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      built_q     <= '0;
      valid_tab_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      built_q     <= built_d;
      valid_tab_q <= valid_tab_d;
      if (deliver) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    lim_q  <= lim_d;
    n_q    <= n_d;
    r_q    <= r_d;
    acc_q  <= acc_d;
    sq_q   <= sq_d;
    a_q    <= a_d;
    b_q    <= b_d;
    rem_q  <= rem_d;
    prod_q <= prod_d;
    cnt_q  <= cnt_d;
    e_q    <= e_d;
    resv_q <= resv_d;
    rese_q <= rese_d;
    if (deliver) begin
      out_q.value <= resv_q;
      out_q.error <= rese_q;
    end
  end

endmodule
`default_nettype wire
